// ===== hdl/wrr_pkg.sv =====
// ----------------------------------------------------------------------------
// wrr_pkg
// shared types and constants for the three-axis window rank and range block
// ----------------------------------------------------------------------------
package wrr_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int RANK_W     = 7;
   localparam int SPREAD_W   = 10;
   localparam int RANK_SCALE = 100;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 10'sh200;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 10'sh1FF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic        [RANK_W-1:0]   rank_type;
   typedef logic        [SPREAD_W-1:0] spread_type;

   // control from the sequencer to each axis accumulator
   typedef struct packed {
      logic clear;   // start of a new item
      logic step;    // one window entry is on the entry input
   } axis_ctl_type;

endpackage

// ===== hdl/wrr_mem.sv =====
// ----------------------------------------------------------------------------
// wrr_mem
// single-port-write, single-port-read sample memory with registered read
// ----------------------------------------------------------------------------
module wrr_mem #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 30
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/wrr_axis.sv =====
// ----------------------------------------------------------------------------
// wrr_axis
// per-axis accumulator: rank count scaled to percent, running min and max
// ----------------------------------------------------------------------------
module wrr_axis #(
   parameter int WINDOW = 32
) (
   input  logic                  clock,
   input  wrr_pkg::axis_ctl_type ctl,
   input  wrr_pkg::sample_type   sample,
   input  wrr_pkg::sample_type   entry,
   output wrr_pkg::rank_type     rank,
   output wrr_pkg::spread_type   spread
);
   import wrr_pkg::*;

   localparam int AW    = $clog2(WINDOW);
   localparam int Q_DIV = RANK_SCALE / WINDOW;
   localparam int R_MOD = RANK_SCALE % WINDOW;

   rank_type    quot_ff, quot_in;
   logic [AW-1:0] rem_ff, rem_in;
   sample_type  lo_ff, lo_in;
   sample_type  hi_ff, hi_in;

   logic [AW:0]     rem_sum;
   logic [SAMPLE_W:0] diff;

   // count * 100 / WINDOW kept as quotient and remainder, one entry a step
   always_comb begin
      rem_sum = {1'b0, rem_ff} + (AW+1)'(R_MOD);
      quot_in = quot_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      if (ctl.clear) begin
         quot_in = '0;
         rem_in  = '0;
         lo_in   = SAMPLE_MAX;
         hi_in   = SAMPLE_MIN;
      end else if (ctl.step) begin
         if (sample >= entry) begin
            if (rem_sum >= (AW+1)'(WINDOW)) begin
               rem_in  = AW'(rem_sum - (AW+1)'(WINDOW));
               quot_in = quot_ff + RANK_W'(Q_DIV) + RANK_W'(1);
            end else begin
               rem_in  = rem_sum[AW-1:0];
               quot_in = quot_ff + RANK_W'(Q_DIV);
            end
         end
         if (entry < lo_ff) begin
            lo_in = entry;
         end
         if (entry > hi_ff) begin
            hi_in = entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
   end

   assign diff   = {hi_ff[SAMPLE_W-1], hi_ff} - {lo_ff[SAMPLE_W-1], lo_ff};
   assign rank   = quot_ff;
   assign spread = diff[SPREAD_W-1:0];

endmodule

// ===== hdl/window_rank_and_range_3axis_core.sv =====
// ----------------------------------------------------------------------------
// window_rank_and_range_3axis_core
// sliding-window percentile rank and min/max range for a three-axis sample
// ----------------------------------------------------------------------------
// req channel: one transfer carries a sample (x, y, z). rsp channel: one
// transfer per sample carries the rank of each axis against the window, the
// range of each axis over the window before the update, and the flag for an
// all-minus-one reading. The window of the last WINDOW samples lives in one
// synchronous memory; a sample walks it one entry per cycle through the
// single read port, then overwrites the oldest entry.
// A new sample is taken only once the previous one is placed in the output
// register, after its walk through the memory read port.
// Reset: the window reads as all zero; entries not yet written are masked by
// a fill count, so there is no clearing pass. A stalled rsp holds its result;
// the next sample is still taken and walked, and it waits for the output
// register only at its end.
// ----------------------------------------------------------------------------
module window_rank_and_range_3axis_core #(
   parameter int WINDOW = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // accel_x, accel_y, accel_z, pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // rank_x, rank_y, rank_z, spread_x,
                                    // spread_y, spread_z, sensor_absent, pad
);
   import wrr_pkg::*;

   localparam int AW     = $clog2(WINDOW);
   localparam int FW     = $clog2(WINDOW + 1);
   localparam int WORD_W = 3 * SAMPLE_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     newest_ff, newest_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_idx_ff;
   logic [WORD_W-1:0] sample_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [55:0]       rsp_data_ff;

   logic              req_fire;
   logic              issue;
   logic              finish;
   logic              entry_ok;
   logic [AW-1:0]     slot;
   logic [WORD_W-1:0] rd_word;
   logic [WORD_W-1:0] entry_word;
   logic              absent;
   axis_ctl_type      ctl;
   rank_type          rank_x, rank_y, rank_z;
   spread_type        spread_x, spread_y, spread_z;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign issue      = (state_ff == ST_SCAN);
   assign finish     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign slot       = (newest_ff == AW'(WINDOW - 1)) ? '0 : newest_ff + AW'(1);

   // writes land at slot 1, 2, ... and slot 0 last, so a fill count tells
   // which entries are not yet written; those are masked to read as zero
   assign entry_ok   = (fill_ff == FW'(WINDOW)) ||
                       ((rd_idx_ff != '0) && (FW'(rd_idx_ff) <= fill_ff));
   assign entry_word = entry_ok ? rd_word : '0;

   assign ctl.clear  = req_fire;
   assign ctl.step   = rd_vld_ff;

   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      newest_in = newest_ff;
      fill_in   = fill_ff;
      rd_vld_in = issue;
      unique case (state_ff)
         ST_IDLE: begin
            addr_in = '0;
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(WINDOW - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (finish) begin
               state_in  = ST_IDLE;
               newest_in = slot;
               if (fill_ff != FW'(WINDOW)) begin
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         newest_ff    <= '0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         newest_ff    <= newest_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      if (req_fire) begin
         sample_ff <= req_tdata[WORD_W-1:0];
      end
      if (finish) begin
         rsp_data_ff <= {4'b0000, absent, spread_z, spread_y, spread_x,
                         rank_z, rank_y, rank_x};
      end
   end

   assign absent = (sample_ff == {WORD_W{1'b1}});

   wrr_mem #(
      .DEPTH (WINDOW),
      .WIDTH (WORD_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (finish),
      .wr_addr (slot),
      .wr_data (sample_ff),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   wrr_axis #(.WINDOW(WINDOW)) u_axis_x (
      .clock  (clock),
      .ctl    (ctl),
      .sample (req_fire ? req_tdata[SAMPLE_W-1:0] : sample_ff[SAMPLE_W-1:0]),
      .entry  (entry_word[SAMPLE_W-1:0]),
      .rank   (rank_x),
      .spread (spread_x)
   );

   wrr_axis #(.WINDOW(WINDOW)) u_axis_y (
      .clock  (clock),
      .ctl    (ctl),
      .sample (sample_ff[2*SAMPLE_W-1:SAMPLE_W]),
      .entry  (entry_word[2*SAMPLE_W-1:SAMPLE_W]),
      .rank   (rank_y),
      .spread (spread_y)
   );

   wrr_axis #(.WINDOW(WINDOW)) u_axis_z (
      .clock  (clock),
      .ctl    (ctl),
      .sample (sample_ff[3*SAMPLE_W-1:2*SAMPLE_W]),
      .entry  (entry_word[3*SAMPLE_W-1:2*SAMPLE_W]),
      .rank   (rank_z),
      .spread (spread_z)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(WINDOW))
      else $error("fill count above window depth");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_LAST))
      else $error("read data outside the window walk");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN && addr_ff == '0))
      else $error("accepted sample did not start the walk at entry zero");

   a_load_frees_input: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result load did not free the input side");
`endif

endmodule

// ===== verif/window_rank_and_range_3axis_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_rank_and_range_3axis_checker
// watches the req and rsp streams, predicts each result and compares it
// ----------------------------------------------------------------------------
// Every accepted req transfer is run through a local copy of the sample
// window to work out the rank and spread for each axis and the absent-sensor
// flag. The expectation waits in a queue until a rsp transfer arrives, and
// the rsp fields are then compared one by one against the oldest entry.
// ----------------------------------------------------------------------------
module window_rank_and_range_3axis_checker #(
   parameter int WINDOW = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // accel_x, accel_y, accel_z, pad
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [55:0] rsp_tdata,   // rank_x, rank_y, rank_z, spread_x,
                                    // spread_y, spread_z, sensor_absent, pad
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   import wrr_pkg::*;

   // fields listed from the top down so the packing matches rsp_tdata
   typedef struct packed {
      logic       absent;
      spread_type spread_z;
      spread_type spread_y;
      spread_type spread_x;
      rank_type   rank_z;
      rank_type   rank_y;
      rank_type   rank_x;
   } window_stats_type;

   sample_type       sample_hist [3][WINDOW];
   int unsigned      newest_slot;
   window_stats_type expected_stats [$];

   task automatic report_mismatch(input string what);
      if (fail_count < 40)
         $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("result %0d %s is %0d, expected %0d",
                                   checked_count, name, got, want));
   endtask

   // rank of one value against one axis of the window, and that axis' spread
   function automatic void scan_axis(input int axis, input sample_type value,
                                     output rank_type rank,
                                     output spread_type spread);
      int lo;
      int hi;
      int not_above;
      lo = int'(sample_hist[axis][0]);
      hi = lo;
      not_above = 0;
      for (int i = 0; i < WINDOW; i++) begin
         if (int'(sample_hist[axis][i]) < lo) lo = int'(sample_hist[axis][i]);
         if (int'(sample_hist[axis][i]) > hi) hi = int'(sample_hist[axis][i]);
         if (int'(value) >= int'(sample_hist[axis][i])) not_above++;
      end
      rank   = rank_type'((not_above * RANK_SCALE) / WINDOW);
      spread = spread_type'(hi - lo);
   endfunction

   function automatic window_stats_type rank_and_spread(input sample_type sx,
                                                        input sample_type sy,
                                                        input sample_type sz);
      window_stats_type st;
      scan_axis(0, sx, st.rank_x, st.spread_x);
      scan_axis(1, sy, st.rank_y, st.spread_y);
      scan_axis(2, sz, st.rank_z, st.spread_z);
      st.absent = (sx == sample_type'(-1)) && (sy == sample_type'(-1)) &&
                  (sz == sample_type'(-1));
      return st;
   endfunction

   always @(posedge clock) begin
      window_stats_type got;
      window_stats_type want;
      sample_type       sx;
      sample_type       sy;
      sample_type       sz;
      if (reset) begin
         foreach (sample_hist[a, i]) sample_hist[a][i] = '0;
         newest_slot = 0;
         expected_stats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = window_stats_type'(rsp_tdata[$bits(window_stats_type)-1:0]);
            if (expected_stats.size() == 0) begin
               report_mismatch("rsp transfer with no sample outstanding");
            end else begin
               want = expected_stats.pop_front();
               check_field("rank_x", got.rank_x, want.rank_x);
               check_field("rank_y", got.rank_y, want.rank_y);
               check_field("rank_z", got.rank_z, want.rank_z);
               check_field("spread_x", got.spread_x, want.spread_x);
               check_field("spread_y", got.spread_y, want.spread_y);
               check_field("spread_z", got.spread_z, want.spread_z);
               check_field("sensor_absent", got.absent, want.absent);
            end
            checked_count++;
         end
         if (req_tvalid && req_tready) begin
            sx = sample_type'(req_tdata[SAMPLE_W-1:0]);
            sy = sample_type'(req_tdata[2*SAMPLE_W-1:SAMPLE_W]);
            sz = sample_type'(req_tdata[3*SAMPLE_W-1:2*SAMPLE_W]);
            expected_stats.push_back(rank_and_spread(sx, sy, sz));
            // the new sample replaces the oldest entry
            newest_slot = (newest_slot + 1) % WINDOW;
            sample_hist[0][newest_slot] = sx;
            sample_hist[1][newest_slot] = sy;
            sample_hist[2][newest_slot] = sz;
         end
      end
      pending_count = expected_stats.size();
   end

endmodule

// ===== verif/window_rank_and_range_3axis_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_rank_and_range_3axis_core_tb
// stimulus and verdict for the three-axis window rank and range block
// ----------------------------------------------------------------------------
// Sends a short directed set of extreme and absent-sensor samples, then
// random samples in free-running, sender-idle, receiver-stall and mixed phases.
// Random samples mix full-range values, extremes, runs of repeats and tight
// clusters so ranks and spreads cover their whole range. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module window_rank_and_range_3axis_core_tb;
   import wrr_pkg::*;

   localparam int WINDOW = 32;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // accel_x, accel_y, accel_z, pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;         // rank_x, rank_y, rank_z, spread_x,
                                   // spread_y, spread_z, sensor_absent, pad

   int fail_count;
   int pending_count;
   int checked_count;
   int sent_count   = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int cluster_base = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   window_rank_and_range_3axis_core #(.WINDOW(WINDOW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   window_rank_and_range_3axis_checker #(.WINDOW(WINDOW)) rank_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   task automatic send_sample(input sample_type sx, input sample_type sy,
                              input sample_type sz);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, sz, sy, sx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   function automatic sample_type pick_value();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0: begin
            case ($urandom_range(3))
               0: return SAMPLE_MIN;
               1: return SAMPLE_MAX;
               2: return sample_type'(-1);
               default: return sample_type'(0);
            endcase
         end
         1, 2, 3: return sample_type'(cluster_base + $urandom_range(16) - 8);
         default: return sample_type'($urandom_range(1023));
      endcase
   endfunction

   task automatic random_phase(input int count, input int idle, input int stall);
      sample_type sx;
      sample_type sy;
      sample_type sz;
      int         repeats;
      idle_pct  = idle;
      stall_pct = stall;
      while (count > 0) begin
         if ($urandom_range(15) == 0) cluster_base = $urandom_range(1023);
         sx = pick_value();
         sy = pick_value();
         sz = pick_value();
         if ($urandom_range(19) == 0) begin
            sx = sample_type'(-1);
            sy = sample_type'(-1);
            sz = sample_type'(-1);
         end
         // occasional runs of one sample push ranks toward the top
         repeats = ($urandom_range(29) == 0) ? $urandom_range(WINDOW + 4, 4) : 1;
         for (int r = 0; r < repeats && count > 0; r++) begin
            send_sample(sx, sy, sz);
            count--;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fresh window of zeros, extremes, absent sensor and near misses
      send_sample(0, 0, 0);
      send_sample(-1, -1, -1);
      send_sample(-1, -1, 0);
      send_sample(0, -1, -1);
      send_sample(-1, 0, -1);
      send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
      send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
      send_sample(SAMPLE_MAX, SAMPLE_MIN, -1);
      send_sample(SAMPLE_MIN, SAMPLE_MAX, 0);
      send_sample(341, -342, 1);
      send_sample(-342, 341, -2);
      send_sample(1, -2, 256);
      send_sample(-256, 255, -1);
      send_sample(-1, -1, -1);
      send_sample(-1, -1, -1);
      send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
      send_sample(SAMPLE_MAX, 0, SAMPLE_MIN);
      send_sample(0, SAMPLE_MAX, SAMPLE_MIN);
      send_sample(-1, SAMPLE_MAX, SAMPLE_MIN);
      send_sample(0, 0, 0);

      random_phase(500, 0, 0);
      random_phase(400, 82, 0);
      random_phase(400, 0, 82);
      random_phase(450, 6, 6);

      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (WINDOW + 8) @(posedge clock);

      $display("%0d samples sent and %0d results checked over directed, free-running,",
               sent_count, checked_count);
      $display("sender-idle, receiver-stall and mixed phases");
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d results still outstanding", pending_count);
      $display("tb: failure");
      $finish;
   end

endmodule
